// File: hdl/hmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmq_pkg
// Shared types and codes for the height map query block: payload structs,
// operation and status codes, controller states, commands and status flags.
// ----------------------------------------------------------------------------
package hmq_pkg;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_HEIGHT = 2'd1,
    OP_RAY    = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_MISS    = 2'd2
  } status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MAP_WIDTH   = 2'd0,
    REG_MAP_DEPTH   = 2'd1,
    REG_COARSE_STEP = 2'd2,
    REG_FINE_STEP   = 2'd3
  } reg_e;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;

  localparam logic [7:0]  MAP_WIDTH_RST   = 8'd128;
  localparam logic [7:0]  MAP_DEPTH_RST   = 8'd128;
  localparam logic [12:0] COARSE_STEP_RST = 13'd256;
  localparam logic [12:0] FINE_STEP_RST   = 13'd26;

  // Internal widths fixed by the field widths
  localparam int ADDR_SUM_W = 17;  // x * width + z before reduction
  localparam int ORG_W      = 18;  // origin in map space
  localparam int T_W        = 18;  // signed march distance
  localparam int P_W        = 22;  // sampled ray point
  localparam int ACC_W      = 22;  // weighted height sum

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        t_near;
    logic [15:0]        t_far;
    logic [6:0]         cell_x;
    logic [6:0]         cell_z;
    logic [12:0]        height_sample;
  } in_t;

  typedef struct packed {
    logic signed [15:0] res_x;
    logic signed [15:0] res_y;
    logic signed [15:0] res_z;
    logic [1:0]         status;
  } out_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_H_CHK,
    S_A_MUL,
    S_A_RECIP,
    S_A_MOD,
    S_WRITE,
    S_READ,
    S_H_ACC,
    S_H_FIN,
    S_R_TEST,
    S_R_MUL,
    S_R_POS,
    S_R_CHK,
    S_R_CMP,
    S_DONE
  } state_e;

  // Datapath commands
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INIT,
    CMD_A_MUL,
    CMD_A_RECIP,
    CMD_A_MOD,
    CMD_WRITE,
    CMD_READ,
    CMD_H_ACC,
    CMD_H_FIN,
    CMD_R_MUL,
    CMD_R_POS,
    CMD_R_STEP,
    CMD_R_HIT,
    CMD_SET_OUT,
    CMD_SET_MISS,
    CMD_PUBLISH
  } cmd_e;

  // Datapath status toward the controller
  typedef struct packed {
    logic [1:0] op;
    logic       h_out;
    logic       k_last;
    logic       r_end;
    logic       r_out;
    logic       below;
    logic       dipped;
    logic       out_stall;
  } stat_t;

endpackage
`default_nettype wire

// File: hdl/hmq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmq_datapath
// Configuration registers, height store, address unit, triangle blend,
// ray march arithmetic and the output register.
// ----------------------------------------------------------------------------
module hmq_datapath #(
  parameter int MAP_DIM         = 128,
  parameter int MAX_MARCH_STEPS = 1024
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  hmq_pkg::in_t                      in_data_i,
  input  wire                               cfg_we_i,
  input  wire [hmq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [hmq_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  hmq_pkg::cmd_e                     cmd_i,
  output hmq_pkg::stat_t                    stat_o,
  input  wire                               out_ready_i,
  output logic                              out_valid_o,
  output hmq_pkg::out_t                     out_data_o
);

  localparam int DEPTH  = MAP_DIM * MAP_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int A_W    = hmq_pkg::ADDR_SUM_W;
  localparam int RECIP  = (2 ** A_W) / DEPTH;
  localparam int N_W    = $clog2(MAX_MARCH_STEPS + 1);
  localparam int P_W    = hmq_pkg::P_W;
  localparam int T_W    = hmq_pkg::T_W;
  localparam int O_W    = hmq_pkg::ORG_W;
  localparam int ACC_W  = hmq_pkg::ACC_W;

  localparam logic [A_W:0]   DEPTH_C = (A_W + 1)'(DEPTH);
  localparam logic [A_W-1:0] RECIP_C = A_W'(RECIP);
  localparam logic [N_W-1:0] MAX_C   = N_W'(MAX_MARCH_STEPS);

  // Clamp to the signed 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [P_W-1:0] v);
    logic signed [15:0] r;
    if (v > $signed(P_W'(32767))) begin
      r = 16'sh7fff;
    end else if (v < -$signed(P_W'(32768))) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [7:0]  width_q, depth_q;
  logic [12:0] coarse_q, fine_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= hmq_pkg::MAP_WIDTH_RST;
      depth_q  <= hmq_pkg::MAP_DEPTH_RST;
      coarse_q <= hmq_pkg::COARSE_STEP_RST;
      fine_q   <= hmq_pkg::FINE_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hmq_pkg::REG_MAP_WIDTH:   width_q  <= cfg_wdata_i[7:0];
        hmq_pkg::REG_MAP_DEPTH:   depth_q  <= cfg_wdata_i[7:0];
        hmq_pkg::REG_COARSE_STEP: coarse_q <= cfg_wdata_i;
        hmq_pkg::REG_FINE_STEP:   fine_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Working registers
  hmq_pkg::in_t              in_q;
  logic signed [O_W-1:0]     ox_q, oz_q;
  logic signed [15:0]        oy_q;
  logic signed [T_W-1:0]     t_q;
  logic [12:0]               step_q;
  logic                      dipped_q;
  logic [N_W-1:0]            n_q;
  logic [1:0]                k_q;
  logic [ACC_W-1:0]          acc_q;
  logic signed [33:0]        mx_q, my_q, mz_q;
  logic signed [P_W-1:0]     px_q, py_q, pz_q;
  logic [A_W-1:0]            asum_q;
  logic [2*A_W-1:0]          qm_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [12:0]               rd_q;
  hmq_pkg::out_t             res_q, out_q;
  logic                      out_valid_q;
  logic [12:0]               mem_q [DEPTH];

  // Map-space helpers
  logic [14:0]               half_w, half_d;
  logic signed [9:0]         wm1, dm1, wm2, dm2, ix_s, iz_s;
  logic signed [P_W-1:0]     xmax, zmax;
  logic [7:0]                ix, iz;
  logic [8:0]                fx, fz;
  logic [9:0]                sum_f;
  logic                      upper;

  assign half_w = {width_q, 7'd0};
  assign half_d = {depth_q, 7'd0};
  assign wm1    = $signed({2'b00, width_q}) - 10'sd1;
  assign dm1    = $signed({2'b00, depth_q}) - 10'sd1;
  assign wm2    = wm1 - 10'sd1;
  assign dm2    = dm1 - 10'sd1;
  assign xmax   = P_W'(wm1) <<< 8;
  assign zmax   = P_W'(dm1) <<< 8;
  assign ix_s   = ox_q[O_W-1:8];
  assign iz_s   = oz_q[O_W-1:8];
  assign ix     = ox_q[15:8];
  assign iz     = oz_q[15:8];
  assign fx     = {1'b0, ox_q[7:0]};
  assign fz     = {1'b0, oz_q[7:0]};
  assign sum_f  = {1'b0, fx} + {1'b0, fz};
  assign upper  = sum_f > 10'd256;

  // Select the corner and weight of the current triangle vertex
  logic [7:0] cx, cz;
  logic [8:0] cw;

  always_comb begin
    case (k_q)
      2'd0: begin
        cx = upper ? ix + 8'd1 : ix;
        cz = iz;
        cw = upper ? 9'(10'd256 - {1'b0, fz}) : 9'(10'd256 - sum_f);
      end
      2'd1: begin
        cx = ix + 8'd1;
        cz = upper ? iz + 8'd1 : iz;
        cw = upper ? 9'(sum_f - 10'd256) : fx;
      end
      default: begin
        cx = ix;
        cz = iz + 8'd1;
        cw = upper ? 9'(10'd256 - {1'b0, fx}) : fz;
      end
    endcase
  end

  // Address source follows the operation
  logic [7:0] ax, az;

  always_comb begin
    case (in_q.operation)
      hmq_pkg::OP_WRITE: begin
        ax = {1'b0, in_q.cell_x};
        az = {1'b0, in_q.cell_z};
      end
      hmq_pkg::OP_HEIGHT: begin
        ax = cx;
        az = cz;
      end
      default: begin
        ax = px_q[15:8];
        az = pz_q[15:8];
      end
    endcase
  end

  // Address reduction modulo the store depth
  logic [15:0]        arow;
  logic [A_W-1:0]     aq;
  logic [2*A_W+1:0]   qd;
  logic [A_W:0]       ar, ar_fix;

  assign arow   = ax * width_q;
  assign aq     = qm_q[2*A_W-1:A_W];
  assign qd     = aq * DEPTH_C;
  assign ar     = {1'b0, asum_q} - qd[A_W:0];
  assign ar_fix = (ar >= DEPTH_C) ? ar - DEPTH_C : ar;

  // Blend and march terms
  logic [ACC_W-1:0]       wprod, rnd;
  logic                   below;
  logic                   r_out;
  logic                   r_end;

  assign wprod = cw * rd_q;
  assign rnd   = acc_q + ACC_W'(128);
  assign below = py_q < $signed({{(P_W-13){1'b0}}, rd_q});
  assign r_out = (px_q < 0) || (pz_q < 0) || (px_q > xmax) || (pz_q > zmax);
  assign r_end = (n_q >= MAX_C) || (t_q >= $signed({2'b00, in_q.t_far}));

  // Sequence the working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      hmq_pkg::CMD_LOAD: begin
        in_q <= in_data_i;
      end
      hmq_pkg::CMD_INIT: begin
        ox_q     <= O_W'(in_q.pos_x) + $signed({3'b000, half_w});
        oz_q     <= O_W'(in_q.pos_z) + $signed({3'b000, half_d});
        oy_q     <= in_q.pos_y;
        t_q      <= $signed({2'b00, in_q.t_near});
        step_q   <= coarse_q;
        dipped_q <= 1'b0;
        n_q      <= '0;
        k_q      <= 2'd0;
        acc_q    <= '0;
        res_q    <= '0;
      end
      hmq_pkg::CMD_A_MUL: begin
        asum_q <= A_W'(arow) + A_W'(az);
      end
      hmq_pkg::CMD_A_RECIP: begin
        qm_q <= asum_q * RECIP_C;
      end
      hmq_pkg::CMD_A_MOD: begin
        addr_q <= ar_fix[ADDR_W-1:0];
      end
      hmq_pkg::CMD_H_ACC: begin
        acc_q <= acc_q + wprod;
        k_q   <= k_q + 2'd1;
      end
      hmq_pkg::CMD_H_FIN: begin
        res_q.res_y <= {2'b00, rnd[ACC_W-1:8]};
      end
      hmq_pkg::CMD_R_MUL: begin
        mx_q <= $signed(in_q.dir_x) * t_q;
        my_q <= $signed(in_q.dir_y) * t_q;
        mz_q <= $signed(in_q.dir_z) * t_q;
      end
      hmq_pkg::CMD_R_POS: begin
        px_q <= P_W'(ox_q) + P_W'(mx_q >>> 14);
        py_q <= P_W'(oy_q) + P_W'(my_q >>> 14);
        pz_q <= P_W'(oz_q) + P_W'(mz_q >>> 14);
      end
      hmq_pkg::CMD_R_STEP: begin
        if (below) begin
          t_q      <= t_q - $signed(T_W'(coarse_q)) + $signed(T_W'(fine_q));
          step_q   <= fine_q;
          dipped_q <= 1'b1;
        end else begin
          t_q <= t_q + $signed(T_W'(step_q));
        end
        n_q <= n_q + N_W'(1);
      end
      hmq_pkg::CMD_R_HIT: begin
        res_q.res_x <= sat16(px_q - $signed(P_W'(half_w)));
        res_q.res_y <= sat16(py_q);
        res_q.res_z <= sat16(pz_q - $signed(P_W'(half_d)));
      end
      hmq_pkg::CMD_SET_OUT: begin
        res_q.status <= hmq_pkg::ST_OUTSIDE;
      end
      hmq_pkg::CMD_SET_MISS: begin
        res_q.status <= hmq_pkg::ST_MISS;
      end
      hmq_pkg::CMD_PUBLISH: begin
        out_q <= res_q;
      end
      default: ;
    endcase
  end

  // Height store: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i == hmq_pkg::CMD_WRITE) begin
      mem_q[addr_q] <= in_q.height_sample;
    end
    if (cmd_i == hmq_pkg::CMD_READ) begin
      rd_q <= mem_q[addr_q];
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == hmq_pkg::CMD_PUBLISH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.op        = in_q.operation;
  assign stat_o.h_out     = (ix_s < 0) || (iz_s < 0) || (ix_s > wm2) || (iz_s > dm2);
  assign stat_o.k_last    = k_q == 2'd2;
  assign stat_o.r_end     = r_end;
  assign stat_o.r_out     = r_out;
  assign stat_o.below     = below;
  assign stat_o.dipped    = dipped_q;
  assign stat_o.out_stall = out_valid_q && !out_ready_i;

endmodule
`default_nettype wire

// File: hdl/hmq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmq_ctrl
// Sequencer for writes, height queries and ray marches; issues one datapath
// command per cycle from its state and the datapath status.
// ----------------------------------------------------------------------------
module hmq_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  hmq_pkg::stat_t  stat_i,
  output hmq_pkg::cmd_e   cmd_o
);

  hmq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hmq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hmq_pkg::S_IDLE: begin
        if (in_valid_i) state_d = hmq_pkg::S_INIT;
      end
      hmq_pkg::S_INIT: begin
        case (stat_i.op)
          hmq_pkg::OP_WRITE:  state_d = hmq_pkg::S_A_MUL;
          hmq_pkg::OP_HEIGHT: state_d = hmq_pkg::S_H_CHK;
          hmq_pkg::OP_RAY:    state_d = hmq_pkg::S_R_TEST;
          default:            state_d = hmq_pkg::S_DONE;
        endcase
      end
      hmq_pkg::S_H_CHK: begin
        state_d = stat_i.h_out ? hmq_pkg::S_DONE : hmq_pkg::S_A_MUL;
      end
      hmq_pkg::S_A_MUL:   state_d = hmq_pkg::S_A_RECIP;
      hmq_pkg::S_A_RECIP: state_d = hmq_pkg::S_A_MOD;
      hmq_pkg::S_A_MOD: begin
        state_d = (stat_i.op == hmq_pkg::OP_WRITE) ? hmq_pkg::S_WRITE : hmq_pkg::S_READ;
      end
      hmq_pkg::S_WRITE: state_d = hmq_pkg::S_DONE;
      hmq_pkg::S_READ: begin
        state_d = (stat_i.op == hmq_pkg::OP_HEIGHT) ? hmq_pkg::S_H_ACC : hmq_pkg::S_R_CMP;
      end
      hmq_pkg::S_H_ACC: begin
        state_d = stat_i.k_last ? hmq_pkg::S_H_FIN : hmq_pkg::S_A_MUL;
      end
      hmq_pkg::S_H_FIN: state_d = hmq_pkg::S_DONE;
      hmq_pkg::S_R_TEST: begin
        state_d = stat_i.r_end ? hmq_pkg::S_DONE : hmq_pkg::S_R_MUL;
      end
      hmq_pkg::S_R_MUL: state_d = hmq_pkg::S_R_POS;
      hmq_pkg::S_R_POS: state_d = hmq_pkg::S_R_CHK;
      hmq_pkg::S_R_CHK: begin
        state_d = stat_i.r_out ? hmq_pkg::S_DONE : hmq_pkg::S_A_MUL;
      end
      hmq_pkg::S_R_CMP: begin
        state_d = (stat_i.below && stat_i.dipped) ? hmq_pkg::S_DONE : hmq_pkg::S_R_TEST;
      end
      hmq_pkg::S_DONE: begin
        if (!stat_i.out_stall) state_d = hmq_pkg::S_IDLE;
      end
      default: state_d = hmq_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = hmq_pkg::CMD_NONE;
    case (state_q)
      hmq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o = hmq_pkg::CMD_LOAD;
      end
      hmq_pkg::S_INIT:    cmd_o = hmq_pkg::CMD_INIT;
      hmq_pkg::S_H_CHK: begin
        if (stat_i.h_out) cmd_o = hmq_pkg::CMD_SET_OUT;
      end
      hmq_pkg::S_A_MUL:   cmd_o = hmq_pkg::CMD_A_MUL;
      hmq_pkg::S_A_RECIP: cmd_o = hmq_pkg::CMD_A_RECIP;
      hmq_pkg::S_A_MOD:   cmd_o = hmq_pkg::CMD_A_MOD;
      hmq_pkg::S_WRITE:   cmd_o = hmq_pkg::CMD_WRITE;
      hmq_pkg::S_READ:    cmd_o = hmq_pkg::CMD_READ;
      hmq_pkg::S_H_ACC:   cmd_o = hmq_pkg::CMD_H_ACC;
      hmq_pkg::S_H_FIN:   cmd_o = hmq_pkg::CMD_H_FIN;
      hmq_pkg::S_R_TEST: begin
        if (stat_i.r_end) cmd_o = hmq_pkg::CMD_SET_MISS;
      end
      hmq_pkg::S_R_MUL:   cmd_o = hmq_pkg::CMD_R_MUL;
      hmq_pkg::S_R_POS:   cmd_o = hmq_pkg::CMD_R_POS;
      hmq_pkg::S_R_CHK: begin
        if (stat_i.r_out) cmd_o = hmq_pkg::CMD_SET_OUT;
      end
      hmq_pkg::S_R_CMP: begin
        cmd_o = (stat_i.below && stat_i.dipped) ? hmq_pkg::CMD_R_HIT : hmq_pkg::CMD_R_STEP;
      end
      hmq_pkg::S_DONE: begin
        if (!stat_i.out_stall) cmd_o = hmq_pkg::CMD_PUBLISH;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/heightmap_height_and_ray_query.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_height_and_ray_query
// Terrain height store with interpolated height queries and ray marching.
// ----------------------------------------------------------------------------
// Usage: one input channel (valid/ready, in_data_i) carries a write, a height
// query or a ray query; one output channel (valid/ready, out_data_o) returns
// exactly one result per input transaction, in order.
// Steps, input accept to result valid:
//   write: one store write; unknown operation: straight to the result
//   height query: three store reads, or none when the point falls off
//   the map
//   ray query: one store read per march sample;
//   the march length bounds it (at most MAX_MARCH_STEPS samples).
// Each store access goes through the address unit (multiply, reduce modulo
// the store depth) and the single store port, which set the per-read cost.
// One item is processed at a time; a finished result sits in the output
// register, so the next transaction is accepted while it waits.
// If the receiver stalls with a result still held, the next result waits in
// the block until the output register frees up.
// Reset clears the state machine and the output valid and sets the
// configuration registers to their defaults; the height store is not
// cleared and must be written before it is read.
// Configuration writes are taken at any clock with cfg_we_i high.
// ----------------------------------------------------------------------------
module heightmap_height_and_ray_query #(
  parameter int MAP_DIM         = 128,
  parameter int MAX_MARCH_STEPS = 1024
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  hmq_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output hmq_pkg::out_t                 out_data_o,
  input  wire                           cfg_we_i,
  input  wire [hmq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [hmq_pkg::CFG_W-1:0]      cfg_wdata_i
);

  hmq_pkg::cmd_e  cmd;
  hmq_pkg::stat_t stat;

  hmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hmq_datapath #(
    .MAP_DIM         (MAP_DIM),
    .MAX_MARCH_STEPS (MAX_MARCH_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// File: hdl/hmq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmq_checker
// Port-level checks of the height map query block, bound to the top level.
// ----------------------------------------------------------------------------
module hmq_checker (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           in_valid_i,
  input wire           in_ready_o,
  input wire           out_valid_o,
  input wire           out_ready_i,
  input hmq_pkg::out_t out_data_o
);

  // Hold a result until the transaction completes
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before acceptance");

  // Busy right after taking an input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("undefined result status");

  // Failed queries carry zero coordinates
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != hmq_pkg::ST_OK) |->
      (out_data_o.res_x == 16'sd0) && (out_data_o.res_y == 16'sd0) &&
      (out_data_o.res_z == 16'sd0))
    else $error("non-zero coordinates on failed query");

endmodule

bind heightmap_height_and_ray_query hmq_checker u_hmq_checker (.*);
`default_nettype wire
